FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies; each macro checks one clocked implication, disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
        else $error("next-cycle implication failed");

`endif

FILE: rtl/bqlp_pkg.sv
// types and constants for the three-channel biquad low-pass filter
// no dependencies; used by bqlp_lane and the top level
`default_nettype none

package bqlp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEFF_FRAC = 16;
    localparam int COEFF_W    = COEFF_FRAC + 2;
    localparam int CHANNELS   = 3;

    // x + 2*x1 + x2 needs two more bits than a sample
    localparam int XSUM_W = SAMPLE_W + 2;
    localparam int FF_W   = COEFF_W + XSUM_W;
    localparam int FB_W   = COEFF_W + SAMPLE_W;
    localparam int ACC_W  = FF_W + 2;
    localparam int RND_W  = ACC_W - COEFF_FRAC;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0_COEFF = 2'd0,
        REG_A1_COEFF = 2'd1,
        REG_A2_COEFF = 2'd2,
        REG_UNUSED   = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_joint_1;
        logic signed [SAMPLE_W-1:0] sample_joint_2;
        logic signed [SAMPLE_W-1:0] sample_joint_3;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] filtered_joint_1;
        logic signed [SAMPLE_W-1:0] filtered_joint_2;
        logic signed [SAMPLE_W-1:0] filtered_joint_3;
    } t_out_item;

    typedef struct packed {
        logic signed [COEFF_W-1:0] b0;
        logic signed [COEFF_W-1:0] a1;
        logic signed [COEFF_W-1:0] a2;
    } t_coeffs;

    // stage enables shared by all lanes
    typedef struct packed {
        logic load;     // input transfer: feed-forward stage captures
        logic advance;  // feed-forward stage moves to the output register
    } t_lane_ctrl;

endpackage

`default_nettype wire

FILE: rtl/biquad_lowpass_three_channel_top.sv
// Three-channel second-order low-pass biquad, direct form I, one lane per joint.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one signed sample
// per joint; output channel (o_out_valid / i_out_ready / o_out_data) returns the
// three rounded, saturated filtered samples of that item.
// Coefficients b0, a1, a2 (signed Q2.16) are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; index 3 is ignored. The user must write them only while no item
// is in flight; the block does not enforce this. An item passes the feed-forward
// product register, then the feedback sum goes into the output register.
// Throughput: one item per cycle while i_out_ready stays high, set by the
// combinational feedback loop of each lane (two products, a three-way add,
// rounding and saturation).
// The input side stays ready while a result waits, as long as the feed-forward
// register is empty; a stalled receiver holds o_out_data and, once both stages
// are full, drops o_in_ready.
// Reset (synchronous, active low) clears coefficients to zero, all sample and
// output histories to zero and both stage valid flags; until the coefficients
// are written every result is zero.
`default_nettype none
`include "assert_macros.svh"

module biquad_lowpass_three_channel_top
    import bqlp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_data,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [COEFF_W-1:0]   i_cfg_data
);

    t_coeffs    r_coeffs;
    logic       r_s1_valid;
    logic       r_out_valid;
    t_out_item  r_out_data;
    t_lane_ctrl w_ctrl;

    logic w_out_free;
    logic w_in_xfer;

    logic signed [SAMPLE_W-1:0] w_x [CHANNELS];
    logic signed [SAMPLE_W-1:0] w_y [CHANNELS];

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeffs <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_B0_COEFF: r_coeffs.b0 <= i_cfg_data;
                REG_A1_COEFF: r_coeffs.a1 <= i_cfg_data;
                REG_A2_COEFF: r_coeffs.a2 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // two-stage pipeline control
    assign w_out_free     = !r_out_valid || i_out_ready;
    assign o_in_ready     = !r_s1_valid || w_out_free;
    assign w_in_xfer      = i_in_valid && o_in_ready;
    assign w_ctrl.load    = w_in_xfer;
    assign w_ctrl.advance = r_s1_valid && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (w_ctrl.advance) begin
                r_s1_valid <= 1'b0;
            end
            if (w_ctrl.advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_x[0] = i_in_data.sample_joint_1;
    assign w_x[1] = i_in_data.sample_joint_2;
    assign w_x[2] = i_in_data.sample_joint_3;

    for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
        bqlp_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (w_ctrl),
            .i_coeffs (r_coeffs),
            .i_x      (w_x[g]),
            .o_y      (w_y[g])
        );
    end

    // merge the lane results into one output item
    always_ff @(posedge i_clk) begin
        if (w_ctrl.advance) begin
            r_out_data.filtered_joint_1 <= w_y[0];
            r_out_data.filtered_joint_2 <= w_y[1];
            r_out_data.filtered_joint_3 <= w_y[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_IMPLIES(a_full_not_ready, i_clk, i_rst_n,
        r_s1_valid && r_out_valid && !i_out_ready, !o_in_ready)
    `ASSERT_NEXT(a_xfer_fills_s1, i_clk, i_rst_n, w_in_xfer, r_s1_valid)
    `ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, w_ctrl.advance, r_out_valid)
    `ASSERT_NEXT(a_out_needs_source, i_clk, i_rst_n,
        !r_s1_valid && (!r_out_valid || i_out_ready), !r_out_valid)

endmodule

`default_nettype wire

FILE: rtl/bqlp_lane.sv
// one channel of the direct form I biquad: feed-forward stage and feedback loop
// depends on bqlp_pkg
`default_nettype none

module bqlp_lane
    import bqlp_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_lane_ctrl                 i_ctrl,
    input  wire t_coeffs                    i_coeffs,
    input  wire logic signed [SAMPLE_W-1:0] i_x,
    output logic signed [SAMPLE_W-1:0]      o_y
);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEFF_FRAC - 1);
    localparam logic signed [RND_W-1:0] SAT_MAX    = RND_W'((2 ** (SAMPLE_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] SAT_MIN    = -SAT_MAX - RND_W'(1);

    logic signed [SAMPLE_W-1:0] r_x1;
    logic signed [SAMPLE_W-1:0] r_x2;
    logic signed [SAMPLE_W-1:0] r_y1;
    logic signed [SAMPLE_W-1:0] r_y2;
    logic signed [FF_W-1:0]     r_ff;

    logic signed [XSUM_W-1:0] w_xsum;
    logic signed [FF_W-1:0]   w_ff;
    logic signed [FB_W-1:0]   w_fb1;
    logic signed [FB_W-1:0]   w_fb2;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [RND_W-1:0]  w_rnd;
    logic signed [SAMPLE_W-1:0] w_y;

    // feed-forward part does not depend on the output history, so it runs a stage early
    assign w_xsum = XSUM_W'(i_x) + (XSUM_W'(r_x1) <<< 1) + XSUM_W'(r_x2);
    assign w_ff   = i_coeffs.b0 * w_xsum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1 <= '0;
            r_x2 <= '0;
        end else if (i_ctrl.load) begin
            r_x1 <= i_x;
            r_x2 <= r_x1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_ff <= w_ff;
        end
    end

    // feedback loop is combinational from the output history registers back to them
    assign w_fb1 = i_coeffs.a1 * r_y1;
    assign w_fb2 = i_coeffs.a2 * r_y2;
    assign w_acc = ACC_W'(r_ff) - ACC_W'(w_fb1) - ACC_W'(w_fb2) + ROUND_HALF;
    // arithmetic drop of the fraction bits is a floor
    assign w_rnd = w_acc[ACC_W-1:COEFF_FRAC];

    always_comb begin
        if (w_rnd > SAT_MAX) begin
            w_y = SAT_MAX[SAMPLE_W-1:0];
        end else if (w_rnd < SAT_MIN) begin
            w_y = SAT_MIN[SAMPLE_W-1:0];
        end else begin
            w_y = w_rnd[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y1 <= '0;
            r_y2 <= '0;
        end else if (i_ctrl.advance) begin
            r_y1 <= w_y;
            r_y2 <= r_y1;
        end
    end

    assign o_y = w_y;

endmodule

`default_nettype wire

FILE: tb/tb_biquad_lowpass_three_channel_top.sv
`timescale 1ns / 1ps
// self-checking testbench for biquad_lowpass_three_channel_top
// depends on bqlp_pkg and the top level; a bit-accurate filter model in the bench
// predicts every output transfer, with random gaps on both handshake sides

module tb_biquad_lowpass_three_channel_top;
    import bqlp_pkg::*;

    localparam int     LATENCY_WAIT    = 6;
    localparam int     CYCLE_LIMIT     = 600000;
    localparam int     MAX_REPORTS     = 30;
    localparam int     RANDOM_PHASES   = 10;
    localparam int     ITEMS_PER_PHASE = 153;
    localparam longint ROUND_HALF      = 64'sd1 <<< (COEFF_FRAC - 1);
    localparam longint SAMPLE_MAX      = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN      = -SAMPLE_MAX - 1;
    localparam int     COEFF_MAX       = (1 << (COEFF_W - 1)) - 1;
    localparam int     COEFF_MIN       = -(1 << (COEFF_W - 1));

    // butterworth sets for fc/fs of 0.1, 0.02 and 0.25 in Q2.16
    localparam int BW_B0 [3] = '{4422, 237, 19196};
    localparam int BW_A1 [3] = '{-74906, -119455, 0};
    localparam int BW_A2 [3] = '{27053, 54874, 11244};

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    t_in_item             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            out_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [COEFF_W-1:0]   cfg_data  = '0;

    // filter model state
    logic signed [COEFF_W-1:0] coeff_b0 = '0;
    logic signed [COEFF_W-1:0] coeff_a1 = '0;
    logic signed [COEFF_W-1:0] coeff_a2 = '0;
    longint hist_x1 [CHANNELS] = '{default: 0};
    longint hist_x2 [CHANNELS] = '{default: 0};
    longint hist_y1 [CHANNELS] = '{default: 0};
    longint hist_y2 [CHANNELS] = '{default: 0};

    t_out_item pending_filtered [$];
    int        n_sent       = 0;
    int        n_checked    = 0;
    int        n_mismatches = 0;
    int        n_settings   = 0;
    int        cycle_count  = 0;
    bit        in_no_idle   = 1'b0;
    bit        out_no_stall = 1'b0;
    int        out_stall_left = 0;

    biquad_lowpass_three_channel_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // direct form I step for all joints; updates the histories
    function automatic t_out_item filter_sample(input t_in_item s);
        longint    x [CHANNELS];
        longint    acc;
        t_out_item r;
        x[0] = s.sample_joint_1;
        x[1] = s.sample_joint_2;
        x[2] = s.sample_joint_3;
        for (int c = 0; c < CHANNELS; c++) begin
            acc = longint'(coeff_b0) * (x[c] + 2 * hist_x1[c] + hist_x2[c])
                - longint'(coeff_a1) * hist_y1[c]
                - longint'(coeff_a2) * hist_y2[c] + ROUND_HALF;
            acc = acc >>> COEFF_FRAC;
            if (acc > SAMPLE_MAX) acc = SAMPLE_MAX;
            if (acc < SAMPLE_MIN) acc = SAMPLE_MIN;
            hist_y2[c] = hist_y1[c];
            hist_y1[c] = acc;
            hist_x2[c] = hist_x1[c];
            hist_x1[c] = x[c];
            r[(CHANNELS - 1 - c) * SAMPLE_W +: SAMPLE_W] = acc[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic t_in_item make_item(input int j1, input int j2, input int j3);
        t_in_item s;
        s.sample_joint_1 = SAMPLE_W'(j1);
        s.sample_joint_2 = SAMPLE_W'(j2);
        s.sample_joint_3 = SAMPLE_W'(j3);
        return s;
    endfunction

    // mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // torque-like stream: random walk per joint mixed with jumps, extremes and noise
    function automatic t_in_item next_stream_item(input t_in_item prev);
        t_in_item s;
        int       v;
        int       r;
        for (int c = 0; c < CHANNELS; c++) begin
            r = $urandom_range(0, 99);
            v = $signed(prev[(CHANNELS - 1 - c) * SAMPLE_W +: SAMPLE_W]);
            if (r < 35) begin
                v = $signed(SAMPLE_W'($urandom));
            end else if (r < 70) begin
                v = v + $urandom_range(0, 2000) - 1000;
                if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                if (v < SAMPLE_MIN) v = SAMPLE_MIN;
            end else if (r < 82) begin
                v = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            end else begin
                v = $urandom_range(0, 64) - 32;
            end
            s[(CHANNELS - 1 - c) * SAMPLE_W +: SAMPLE_W] = SAMPLE_W'(v);
        end
        return s;
    endfunction

    task automatic send_sample(input t_in_item s);
        int gap;
        gap = in_no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (!in_ready);
        pending_filtered.insert(pending_filtered.size(), filter_sample(s));
        n_sent++;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_filtered.size() != 0) @(posedge clk);
        repeat (LATENCY_WAIT) @(posedge clk);
    endtask

    // leaves the write enable high; the caller lowers it after the last write
    task automatic write_reg(input t_cfg_reg idx, input logic [COEFF_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_B0_COEFF: coeff_b0 = val;
            REG_A1_COEFF: coeff_a1 = val;
            REG_A2_COEFF: coeff_a2 = val;
            default: ;
        endcase
    endtask

    task automatic set_coeffs(input int b0, input int a1, input int a2);
        wait_idle();
        write_reg(REG_B0_COEFF, COEFF_W'(b0));
        write_reg(REG_A1_COEFF, COEFF_W'(a1));
        write_reg(REG_A2_COEFF, COEFF_W'(a2));
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // coefficients come out of reset at zero, so every result is zero
    task automatic test_reset_default();
        send_sample(make_item(SAMPLE_MAX, SAMPLE_MIN, 1));
        send_sample(make_item(SAMPLE_MIN, SAMPLE_MAX, -1));
        send_sample(make_item(12345, -4321, 0));
    endtask

    // b0 of one half turns odd input sums into exact halves; ties go up
    task automatic test_rounding_ties();
        set_coeffs(32768, 0, 0);
        send_sample(make_item(0, 0, 0));
        send_sample(make_item(0, 0, 0));
        send_sample(make_item(1, -1, 3));
        send_sample(make_item(0, 0, 0));
        send_sample(make_item(0, 0, 0));
        send_sample(make_item(-3, 2, -1));
        send_sample(make_item(0, 0, 0));
        send_sample(make_item(0, 0, 0));
    endtask

    // largest gains drive both rails and feed saturated values back
    task automatic test_saturation_feedback();
        set_coeffs(COEFF_MAX, COEFF_MIN, COEFF_MAX);
        send_sample(make_item(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX));
        send_sample(make_item(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN));
        send_sample(make_item(SAMPLE_MIN, SAMPLE_MAX, 0));
        send_sample(make_item(0, 0, 0));
        send_sample(make_item(-1, 1, SAMPLE_MAX));
        send_sample(make_item(0, 0, 0));
    endtask

    // a write to the spare index must leave the coefficients alone
    task automatic test_unused_register();
        set_coeffs(COEFF_MIN, COEFF_MAX, COEFF_MIN);
        @(posedge clk);
        write_reg(REG_UNUSED, COEFF_W'($urandom));
        cfg_we <= 1'b0;
        repeat (4) send_sample(make_item($urandom, $urandom, $urandom));
    endtask

    task automatic test_random_streams();
        t_in_item s;
        int       kind;
        int       k;
        s = '0;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            kind = $urandom_range(0, 3);
            if (kind < 2) begin
                k = $urandom_range(0, 2);
                set_coeffs(BW_B0[k] + $urandom_range(0, 128) - 64,
                           BW_A1[k] + $urandom_range(0, 128) - 64,
                           BW_A2[k] + $urandom_range(0, 128) - 64);
            end else if (kind == 2) begin
                set_coeffs($urandom, $urandom, $urandom);
            end else begin
                set_coeffs($urandom_range(0, 1) ? COEFF_MAX : COEFF_MIN,
                           $urandom_range(0, 1) ? COEFF_MAX : COEFF_MIN,
                           $urandom_range(0, 1) ? COEFF_MAX : 0);
            end
            // first phases run back to back on one or both sides
            in_no_idle   = (p == 0) || (p == 1) || ($urandom_range(0, 3) == 0);
            out_no_stall = (p == 0) || ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                s = next_stream_item(s);
                send_sample(s);
            end
        end
        in_no_idle   = 1'b0;
        out_no_stall = 1'b0;
    endtask

    always @(posedge clk) begin
        if (out_stall_left > 0) begin
            out_stall_left--;
            out_ready <= 1'b0;
        end else begin
            out_stall_left = out_no_stall ? 0 : pick_gap();
            out_ready <= (out_stall_left == 0);
            if (out_stall_left > 0) out_stall_left--;
        end
    end

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_filtered.size() == 0) begin
                n_mismatches++;
                if (n_mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected output transfer %h", $time, out_data);
            end else begin
                want = pending_filtered.pop_front();
                n_checked++;
                for (int c = 0; c < CHANNELS; c++) begin
                    if (out_data[(CHANNELS - 1 - c) * SAMPLE_W +: SAMPLE_W] !==
                        want[(CHANNELS - 1 - c) * SAMPLE_W +: SAMPLE_W]) begin
                        n_mismatches++;
                        if (n_mismatches <= MAX_REPORTS)
                            $display("%0t: filtered_joint_%0d expected %0d got %0d",
                                     $time, c + 1,
                                     $signed(want[(CHANNELS - 1 - c) * SAMPLE_W +: SAMPLE_W]),
                                     $signed(out_data[(CHANNELS - 1 - c) * SAMPLE_W +: SAMPLE_W]));
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_filtered.size());
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_default();
        test_rounding_ties();
        test_saturation_feedback();
        test_unused_register();
        test_random_streams();
        wait_idle();
        $display("sent %0d samples per joint, checked %0d results, %0d mismatches",
                 n_sent, n_checked, n_mismatches);
        $display("coefficient sets: %0d (reset zero, rounding, rails, spare index, random)",
                 n_settings);
        if (n_mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
